@@ hw/rtl/ece_pkg.sv @@
package ece_pkg;

  localparam int STATE_W      = 5;
  localparam int MAX_ROWS     = 32;
  localparam int STATES_DFLT  = 32;
  localparam int IN_TDATA_W   = 16;
  localparam int OUT_TDATA_W  = 32;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD_WR,
    ST_EXPAND
  } state_e;

  typedef struct packed {
    logic                rd_en;
    logic [STATE_W-1:0]  rd_addr;
    logic                wr_en;
    logic [STATE_W-1:0]  wr_addr;
    logic [MAX_ROWS-1:0] wr_data;
    logic                clr;
  } store_req_t;

endpackage

@@ hw/rtl/ece_ram.sv @@
module ece_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/ece_edge_store.sv @@
module ece_edge_store import ece_pkg::*; #(
  parameter int ROWS   = MAX_ROWS,
  parameter int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  store_req_t      req_i,
  output logic [ROWS-1:0] row_o
);

  logic [ROWS-1:0]   valid_q;
  logic              rd_valid_q;
  logic [ROWS-1:0]   ram_rdata;
  logic [ROW_AW-1:0] rd_idx;
  logic [ROW_AW-1:0] wr_idx;

  assign rd_idx = req_i.rd_addr[ROW_AW-1:0];
  assign wr_idx = req_i.wr_addr[ROW_AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.clr) begin
        valid_q <= '0;
      end else if (req_i.wr_en) begin
        valid_q[wr_idx] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_valid_q <= valid_q[rd_idx];
      end
    end
  end

  ece_ram #(
    .WIDTH (ROWS),
    .DEPTH (ROWS),
    .AW    (ROW_AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (req_i.wr_en),
    .waddr_i (wr_idx),
    .wdata_i (req_i.wr_data[ROWS-1:0]),
    .re_i    (req_i.rd_en),
    .raddr_i (rd_idx),
    .rdata_o (ram_rdata)
  );

  assign row_o = ram_rdata & {ROWS{rd_valid_q}};

endmodule

@@ hw/rtl/epsilon_closure_engine_unit.sv @@
// Epsilon closure engine over the epsilon edges of an automaton.
// Input beats arrive on the s_axis channel; tdata carries cmd, state_a and
// state_b. An add command sets one edge and returns no beat. A clear command
// drops all edges at once and returns no beat. A query returns one beat on
// m_axis whose tdata is the closure mask of state_a.
// The block works on one command at a time. An add first reads the source
// row from the edge memory and then writes it back with the new edge set. A
// query reads one adjacency row per reached state through the single read
// port of the edge memory, which delivers one adjacency row per cycle.
// The result sits in an output register; the next command is accepted while
// it waits. When the receiver stalls and a second query finishes, the engine
// holds that query until the output register is free.
// Reset clears all edges through per-row valid bits, so no clearing pass is
// needed, and leaves the output channel empty.
module epsilon_closure_engine_unit import ece_pkg::*; #(
  parameter int STATES = STATES_DFLT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // cmd [1:0], state_a [6:2], state_b [11:7], zero [15:12]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // closure_mask [31:0]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int ROWS   = (STATES < MAX_ROWS) ? STATES : MAX_ROWS;
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [STATE_W:0] ROWS_L = (STATE_W + 1)'(ROWS);

  state_e            state_q, state_d;
  logic [ROWS-1:0]   reached_q, reached_d;
  logic [ROWS-1:0]   frontier_q, frontier_d;
  logic              pend_q, pend_d;
  logic [ROW_AW-1:0] add_a_q, add_a_d;
  logic [ROW_AW-1:0] add_b_q, add_b_d;
  logic [OUT_TDATA_W-1:0] out_q, out_d;
  logic              out_valid_q, out_valid_d;

  cmd_e              in_cmd;
  logic [STATE_W-1:0] in_a;
  logic [STATE_W-1:0] in_b;
  logic              a_live, b_live;
  logic              in_fire;
  logic [ROW_AW-1:0] start_idx;

  store_req_t        req;
  logic [ROWS-1:0]   row;
  logic [ROWS-1:0]   fresh;
  logic [ROWS-1:0]   reached_m;
  logic [ROWS-1:0]   frontier_m;
  logic [ROWS-1:0]   pick;
  logic [ROW_AW-1:0] pick_idx;
  logic              out_free;

  assign in_cmd    = cmd_e'(s_axis_tdata[1:0]);
  assign in_a      = s_axis_tdata[6:2];
  assign in_b      = s_axis_tdata[11:7];
  assign a_live    = {1'b0, in_a} < ROWS_L;
  assign b_live    = {1'b0, in_b} < ROWS_L;
  assign start_idx = in_a[ROW_AW-1:0];
  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign out_free  = !out_valid_q || m_axis_tready;

  assign fresh      = pend_q ? (row & ~reached_q) : '0;
  assign reached_m  = reached_q | fresh;
  assign frontier_m = frontier_q | fresh;
  assign pick       = frontier_m & (~frontier_m + {{(ROWS-1){1'b0}}, 1'b1});

  always_comb begin
    pick_idx = '0;
    for (int i = 0; i < ROWS; i++) begin
      if (pick[i]) begin
        pick_idx = pick_idx | ROW_AW'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    reached_q  <= reached_d;
    frontier_q <= frontier_d;
    add_a_q    <= add_a_d;
    add_b_q    <= add_b_d;
    out_q      <= out_d;
  end

  always_comb begin
    state_d       = state_q;
    reached_d     = reached_q;
    frontier_d    = frontier_q;
    pend_d        = 1'b0;
    add_a_d       = add_a_q;
    add_b_d       = add_b_q;
    out_d         = out_q;
    out_valid_d   = out_valid_q && !m_axis_tready;
    s_axis_tready = 1'b0;
    req           = '0;

    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (in_fire) begin
          case (in_cmd)
            CMD_ADD: begin
              if (a_live && b_live) begin
                req.rd_en   = 1'b1;
                req.rd_addr = in_a;
                add_a_d     = start_idx;
                add_b_d     = in_b[ROW_AW-1:0];
                state_d     = ST_ADD_WR;
              end
            end
            CMD_QUERY: begin
              if (a_live) begin
                reached_d  = {{(ROWS-1){1'b0}}, 1'b1} << start_idx;
                frontier_d = {{(ROWS-1){1'b0}}, 1'b1} << start_idx;
              end else begin
                reached_d  = '0;
                frontier_d = '0;
              end
              state_d = ST_EXPAND;
            end
            CMD_CLEAR: begin
              req.clr = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_ADD_WR: begin
        req.wr_en   = 1'b1;
        req.wr_addr = STATE_W'(add_a_q);
        req.wr_data = MAX_ROWS'(row | ({{(ROWS-1){1'b0}}, 1'b1} << add_b_q));
        state_d     = ST_IDLE;
      end
      ST_EXPAND: begin
        reached_d = reached_m;
        if (frontier_m != '0) begin
          req.rd_en   = 1'b1;
          req.rd_addr = STATE_W'(pick_idx);
          frontier_d  = frontier_m & ~pick;
          pend_d      = 1'b1;
        end else begin
          frontier_d = '0;
          if (out_free) begin
            out_d       = OUT_TDATA_W'(reached_m);
            out_valid_d = 1'b1;
            state_d     = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  ece_edge_store #(
    .ROWS   (ROWS),
    .ROW_AW (ROW_AW)
  ) u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .row_o  (row)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXPAND) |-> ((frontier_q & ~reached_q) == '0))
    else $error("frontier holds a state outside the reached set");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == ST_EXPAND))
    else $error("row read pending outside of a query");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_cmd == CMD_QUERY && a_live) |=> reached_q[$past(start_idx)])
    else $error("query start state missing from the reached set");

endmodule

@@ bench/epsilon_closure_engine_unit_tb.sv @@
module epsilon_closure_engine_unit_tb import ece_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RAND_BEATS = 530;
  localparam int IDLE_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 50;
  localparam int DIR_ROWS = 21;

  typedef struct {
    logic [1:0]          cmd;
    logic [STATE_W-1:0]  state_a;
    logic [STATE_W-1:0]  state_b;
    bit                  typed;
    logic [MAX_ROWS-1:0] mask;
  } cmd_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  logic [MAX_ROWS-1:0] edge_rows [MAX_ROWS];
  logic [MAX_ROWS-1:0] pending_closures [$];
  cmd_row_t            dir_rows [DIR_ROWS];

  int errors = 0;
  int idle_cycles = 0;
  int send_calm = 0;
  int recv_calm = 0;
  int recv_stall = 0;
  int n_add = 0;
  int n_query = 0;
  int n_clear = 0;
  int n_unused = 0;
  int n_checked = 0;
  int widest = 0;

  epsilon_closure_engine_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [MAX_ROWS-1:0] closure_of(logic [STATE_W-1:0] start);
    logic [MAX_ROWS-1:0] reached;
    logic [MAX_ROWS-1:0] frontier;
    logic [MAX_ROWS-1:0] fresh;
    int row;
    reached = {{(MAX_ROWS-1){1'b0}}, 1'b1} << start;
    frontier = reached;
    while (frontier != '0) begin
      row = 0;
      while (!frontier[row]) row++;
      frontier[row] = 1'b0;
      fresh = edge_rows[row] & ~reached;
      reached |= fresh;
      frontier |= fresh;
    end
    return reached;
  endfunction

  task automatic track_beat(input cmd_row_t row);
    logic [MAX_ROWS-1:0] mask;
    case (row.cmd)
      CMD_ADD: begin
        edge_rows[row.state_a][row.state_b] = 1'b1;
        n_add++;
      end
      CMD_QUERY: begin
        mask = row.typed ? row.mask : closure_of(row.state_a);
        pending_closures.push_back(mask);
        n_query++;
      end
      CMD_CLEAR: begin
        foreach (edge_rows[i]) edge_rows[i] = '0;
        n_clear++;
      end
      default: begin
        n_unused++;
      end
    endcase
  endtask

  task automatic send_beat(input cmd_row_t row);
    int gap;
    if (send_calm > 0) begin
      send_calm--;
      gap = 0;
    end else begin
      gap = pick_gap();
      if ($urandom_range(0, 29) == 0) send_calm = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, row.state_b, row.state_a, row.cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    track_beat(row);
  endtask

  always @(posedge clk_i) begin
    if (recv_stall > 0) begin
      m_axis_tready <= 1'b0;
      recv_stall--;
    end else begin
      m_axis_tready <= 1'b1;
      if (recv_calm > 0) begin
        recv_calm--;
      end else if ($urandom_range(0, 3) == 0) begin
        recv_stall = pick_gap();
        if ($urandom_range(0, 9) == 0) recv_calm = $urandom_range(20, 80);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_closures.size() == 0) begin
        $display("%0t: unexpected closure beat, expected none, got %08h",
                 $time, m_axis_tdata);
        errors++;
      end else begin
        if (m_axis_tdata !== pending_closures[0]) begin
          $display("%0t: closure mismatch, expected %08h, got %08h",
                   $time, pending_closures[0], m_axis_tdata);
          errors++;
        end
        if ($countones(pending_closures[0]) > widest) widest = $countones(pending_closures[0]);
        void'(pending_closures.pop_front());
        n_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles, %0d closures outstanding",
               $time, IDLE_LIMIT, pending_closures.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    cmd_row_t row;
    int r;
    logic [STATE_W-1:0] chain_tail;

    foreach (edge_rows[i]) edge_rows[i] = '0;
    dir_rows = '{
      '{CMD_QUERY,  5'd0,  5'd0,  1'b1, 32'h0000_0001},
      '{CMD_QUERY,  5'd31, 5'd31, 1'b1, 32'h8000_0000},
      '{CMD_ADD,    5'd0,  5'd31, 1'b0, 32'h0},
      '{CMD_QUERY,  5'd0,  5'd0,  1'b1, 32'h8000_0001},
      '{CMD_ADD,    5'd31, 5'd31, 1'b0, 32'h0},
      '{CMD_QUERY,  5'd31, 5'd0,  1'b1, 32'h8000_0000},
      '{CMD_ADD,    5'd0,  5'd31, 1'b0, 32'h0},
      '{CMD_UNUSED, 5'd0,  5'd1,  1'b0, 32'h0},
      '{CMD_QUERY,  5'd0,  5'd31, 1'b1, 32'h8000_0001},
      '{CMD_ADD,    5'd31, 5'd0,  1'b0, 32'h0},
      '{CMD_ADD,    5'd31, 5'd1,  1'b0, 32'h0},
      '{CMD_ADD,    5'd1,  5'd2,  1'b0, 32'h0},
      '{CMD_ADD,    5'd2,  5'd30, 1'b0, 32'h0},
      '{CMD_QUERY,  5'd31, 5'd0,  1'b0, 32'h0},
      '{CMD_QUERY,  5'd2,  5'd0,  1'b0, 32'h0},
      '{CMD_CLEAR,  5'd31, 5'd31, 1'b0, 32'h0},
      '{CMD_QUERY,  5'd0,  5'd0,  1'b1, 32'h0000_0001},
      '{CMD_QUERY,  5'd30, 5'd0,  1'b1, 32'h4000_0000},
      '{CMD_ADD,    5'd5,  5'd5,  1'b0, 32'h0},
      '{CMD_QUERY,  5'd5,  5'd0,  1'b1, 32'h0000_0020},
      '{CMD_UNUSED, 5'd31, 5'd31, 1'b0, 32'h0}
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_beat(dir_rows[i]);

    chain_tail = $urandom_range(0, 31);
    for (int i = 0; i < RAND_BEATS; i++) begin
      r = $urandom_range(0, 99);
      row.typed   = 1'b0;
      row.mask    = '0;
      row.state_a = $urandom_range(0, 31);
      row.state_b = $urandom_range(0, 31);
      if (r < 1) begin
        row.cmd = CMD_CLEAR;
      end else if (r < 3) begin
        row.cmd = CMD_UNUSED;
      end else if (r < 33) begin
        row.cmd = CMD_QUERY;
        if ($urandom_range(0, 1) == 0) row.state_a = chain_tail;
      end else begin
        row.cmd = CMD_ADD;
        if ($urandom_range(0, 2) != 0) begin
          row.state_a = chain_tail;
          chain_tail  = row.state_b;
        end else if ($urandom_range(0, 7) == 0) begin
          chain_tail = row.state_b;
        end
      end
      send_beat(row);
    end
    s_axis_tvalid <= 1'b0;

    while (pending_closures.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d adds, %0d closure queries, %0d clears and %0d unused commands.",
             n_add, n_query, n_clear, n_unused);
    $display("Checked %0d closure beats; the widest closure held %0d states.",
             n_checked, widest);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
